@@ src/hpc_pkg.sv @@
`default_nettype none
package hpc_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int COUNT_INT_BITS = 24;
    localparam int AMT_W          = COUNT_INT_BITS + FRAC_BITS;
    localparam int PROP_W         = 48;
    localparam int MUL_A_W        = 64;
    localparam int MUL_B_W        = 48;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
    localparam int MUL_R_W        = 63;
    localparam int DIV_N_W        = 56;
    localparam int DIV_D_W        = 32;

    localparam logic [MUL_R_W-1:0] WIDE_LIM = 63'd4611686018427387904;
    localparam logic [MUL_R_W-1:0] PROP_LIM = 63'd140737488355327;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_EULER  = 3'd3;

    localparam logic [2:0] REG_BIRTH     = 3'd0;
    localparam logic [2:0] REG_DEATH     = 3'd1;
    localparam logic [2:0] REG_TURNOVER  = 3'd2;
    localparam logic [2:0] REG_MUTATION  = 3'd3;
    localparam logic [2:0] REG_MIGRATION = 3'd4;
    localparam logic [2:0] REG_CAPACITY  = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_INIT_CNT  = 3'd7;

    typedef struct packed {
        logic start;
        logic wide;
    } mul_ctl_t;

endpackage
`default_nettype wire

@@ src/hpc_serial_mul.sv @@
`default_nettype none
module hpc_serial_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hpc_pkg::mul_ctl_t         ctl,
    input  logic [hpc_pkg::MUL_A_W-1:0] a,
    input  logic [hpc_pkg::MUL_B_W-1:0] b,
    output logic                      done,
    output logic [hpc_pkg::MUL_R_W-1:0] res
);
    import hpc_pkg::*;

    logic [MUL_P_W-1:0] acc_reg;
    logic [MUL_A_W-1:0] a_reg;
    logic               wide_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic [MUL_A_W:0]   sum;
    logic [MUL_P_W-FRAC_BITS-1:0] p16;
    logic [MUL_R_W-1:0] lim;
    logic               over;

    // one multiplier bit per cycle, product shifts right into the low half
    assign sum = {1'b0, acc_reg[MUL_P_W-1:MUL_B_W]} + (acc_reg[0] ? {1'b0, a_reg}
                                                                 : {(MUL_A_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= !ctl.start && busy_reg && (cnt_reg == 6'd1);
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(MUL_B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg  <= {{MUL_A_W{1'b0}}, b};
            a_reg    <= a;
            wide_reg <= ctl.wide;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[MUL_B_W-1:1]};
        end
    end

    assign p16  = acc_reg[MUL_P_W-1:FRAC_BITS];
    assign lim  = wide_reg ? WIDE_LIM : PROP_LIM;
    assign over = (|p16[MUL_P_W-FRAC_BITS-1:MUL_R_W]) || (p16[MUL_R_W-1:0] > lim);
    assign res  = over ? lim : p16[MUL_R_W-1:0];
    assign done = fin_reg;

endmodule
`default_nettype wire

@@ src/hpc_serial_div.sv @@
`default_nettype none
module hpc_serial_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hpc_pkg::DIV_N_W-1:0] dividend,
    input  logic [hpc_pkg::DIV_D_W-1:0] divisor,
    output logic                        done,
    output logic [hpc_pkg::DIV_N_W-1:0] quotient
);
    import hpc_pkg::*;

    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic [DIV_D_W:0]   r_sh;
    logic               fits;

    assign r_sh = {rem_reg, q_reg[DIV_N_W-1]};
    assign fits = r_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= !start && busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? DIV_D_W'(r_sh - {1'b0, d_reg}) : r_sh[DIV_D_W-1:0];
        end
    end

    assign done     = fin_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

@@ src/hybrid_population_cell.sv @@
// Channel   Handshake             Payload
// config    cfg_write             cfg_index, cfg_data
// input     in_valid / in_stall   op, patch_total, time_step
// output    out_valid / out_stall propensities, count_out, flags
//
// One transaction at a time: no new input is taken until the result is loaded into the output register.
// The work per result is done by the shared bit-serial multiplier (three or four
// products per result plus three for an Euler step) and the serial divider
// (two divisions per result when the logistic terms apply).
// Reset is asynchronous and active low; all state is ready right after it.
// A stalled result waits in the output register while the next input is taken.
`default_nettype none
module hybrid_population_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [31:0]        patch_total,
    input  logic [19:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] birth_prop,
    output logic signed [47:0] death_prop,
    output logic signed [47:0] migration_prop,
    output logic signed [47:0] mutation_prop,
    output logic signed [47:0] total_prop,
    output logic [39:0]        count_out,
    output logic               is_discrete,
    output logic               is_active,
    output logic               extinct
);
    import hpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_T1_MUL, S_T1_DIV, S_T2_MUL, S_T2_DIV, S_EVENT, S_E1, S_E2, S_E3,
        S_PREP, S_P0, S_P1, S_P2, S_GM, S_P3, S_FINISH
    } state_t;

    localparam logic [AMT_W-1:0] AMT_MAX = '1;
    localparam logic [AMT_W-1:0] ONE_AMT = AMT_W'(1) << FRAC_BITS;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        mag = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic neg,
                                                      input logic [MUL_R_W-1:0] r);
        apply_sign = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    state_t state_reg;

    logic [23:0] birth_reg, death_reg, turn_reg, mig_reg;
    logic [16:0] mfrac_reg;
    logic [19:0] cap_reg, thr_reg, icnt_reg;

    logic [20:0]      cnt_reg;
    logic [AMT_W-1:0] amt_reg;
    logic             disc_reg, act_reg, ext_reg;

    logic [2:0]  op_reg;
    logic [31:0] patch_reg;
    logic [19:0] dt_reg;
    logic signed [63:0] pb_reg, pd_reg, tmp_reg;
    logic [DIV_N_W-1:0] dp_reg;
    logic [37:0] omgx_reg, gx_reg;
    logic [AMT_W-1:0] gm_reg;
    logic signed [47:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic run_reg;

    logic out_valid_reg, out_disc_reg, out_act_reg, out_ext_reg;
    logic signed [47:0] out_b_reg, out_d_reg, out_m_reg, out_u_reg, out_t_reg;
    logic [39:0] out_cnt_reg;

    logic [16:0] g, omg;
    logic [23:0] diff1, diff2;
    logic        neg1, neg2;
    logic [19:0] k_eff;
    logic        is_mul, is_div;
    mul_ctl_t    mul_ctl;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic        mul_done, div_done;
    logic [MUL_R_W-1:0] mul_res;
    logic [DIV_N_W-1:0] div_q;
    logic signed [63:0] pb_term, pd_term, r1, delta, nv;
    logic [20:0] c_inc, c_dec;
    logic [AMT_W:0] a_inc;
    logic [AMT_W-1:0] a_dec;
    logic signed [49:0] total;
    logic signed [47:0] total_clamped;

    assign g     = (mfrac_reg > 17'(ONE_AMT)) ? 17'(ONE_AMT) : mfrac_reg;
    assign omg   = 17'(ONE_AMT) - g;
    assign neg1  = birth_reg < turn_reg;
    assign neg2  = turn_reg < death_reg;
    assign diff1 = neg1 ? turn_reg - birth_reg : birth_reg - turn_reg;
    assign diff2 = neg2 ? death_reg - turn_reg : turn_reg - death_reg;
    assign k_eff = (cap_reg == 20'd0) ? 20'd1 : cap_reg;

    assign is_mul = state_reg inside {S_E1, S_E2, S_E3, S_P0, S_P1, S_P2, S_GM, S_P3};
    assign is_div = state_reg inside {S_T1_DIV, S_T2_DIV};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_ctl.start = is_mul && !run_reg;
        mul_ctl.wide = 1'b0;
        case (state_reg)
            S_E1:
            begin
                mul_a = mag(pb_reg);
                mul_b = MUL_B_W'(omg);
                mul_ctl.wide = 1'b1;
            end
            S_E2:
            begin
                mul_a = mag(tmp_reg);
                mul_b = MUL_B_W'(amt_reg);
                mul_ctl.wide = 1'b1;
            end
            S_E3:
            begin
                mul_a = mag(tmp_reg);
                mul_b = MUL_B_W'(dt_reg);
                mul_ctl.wide = 1'b1;
            end
            S_P0:
            begin
                mul_a = mag(pb_reg);
                mul_b = MUL_B_W'(omgx_reg);
            end
            S_P1:
            begin
                mul_a = mag(pd_reg);
                mul_b = MUL_B_W'({cnt_reg, {FRAC_BITS{1'b0}}});
            end
            S_P2:
            begin
                mul_a = disc_reg ? MUL_A_W'({cnt_reg, {FRAC_BITS{1'b0}}})
                                 : MUL_A_W'(amt_reg);
                mul_b = MUL_B_W'(mig_reg);
            end
            S_GM:
            begin
                mul_a = MUL_A_W'(amt_reg);
                mul_b = MUL_B_W'(g);
                mul_ctl.wide = 1'b1;
            end
            S_P3:
            begin
                mul_a = mag(pb_reg);
                mul_b = disc_reg ? MUL_B_W'(gx_reg) : MUL_B_W'(gm_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    hpc_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    hpc_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (is_div && !run_reg),
        .dividend (dp_reg),
        .divisor  ({k_eff, 12'd0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pb_term = neg1 ? $signed({40'd0, birth_reg}) + $signed({8'd0, div_q})
                          : $signed({40'd0, birth_reg}) - $signed({8'd0, div_q});
    assign pd_term = neg2 ? $signed({40'd0, death_reg}) - $signed({8'd0, div_q})
                          : $signed({40'd0, death_reg}) + $signed({8'd0, div_q});
    assign r1    = apply_sign(pb_reg[63], mul_res) - pd_reg;
    assign delta = apply_sign(tmp_reg[63], mul_res);
    assign nv    = $signed({24'd0, amt_reg}) + delta;

    assign c_inc = cnt_reg + 21'd1;
    assign c_dec = (cnt_reg != 21'd0) ? cnt_reg - 21'd1 : 21'd0;
    assign a_inc = {1'b0, amt_reg} + {1'b0, ONE_AMT};
    assign a_dec = (amt_reg > ONE_AMT) ? amt_reg - ONE_AMT : '0;

    assign total = 50'(p0_reg) + 50'(p1_reg) + 50'(p2_reg) + 50'(p3_reg);
    assign total_clamped = (total > 50'sd140737488355327) ? 48'sd140737488355327 :
                           (total < -50'sd140737488355327) ? -48'sd140737488355327 :
                           total[47:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            birth_reg     <= '0;
            death_reg     <= '0;
            turn_reg      <= '0;
            mfrac_reg     <= '0;
            mig_reg       <= '0;
            cap_reg       <= 20'd1;
            thr_reg       <= 20'd1;
            icnt_reg      <= '0;
            cnt_reg       <= '0;
            amt_reg       <= '0;
            disc_reg      <= 1'b1;
            act_reg       <= 1'b0;
            ext_reg       <= 1'b0;
            run_reg       <= 1'b0;
            op_reg        <= '0;
            patch_reg     <= '0;
            dt_reg        <= '0;
            pb_reg        <= '0;
            pd_reg        <= '0;
            tmp_reg       <= '0;
            dp_reg        <= '0;
            omgx_reg      <= '0;
            gx_reg        <= '0;
            gm_reg        <= '0;
            p0_reg        <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            p3_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_disc_reg  <= 1'b0;
            out_act_reg   <= 1'b0;
            out_ext_reg   <= 1'b0;
            out_b_reg     <= '0;
            out_d_reg     <= '0;
            out_m_reg     <= '0;
            out_u_reg     <= '0;
            out_t_reg     <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BIRTH:     birth_reg <= cfg_data;
                    REG_DEATH:     death_reg <= cfg_data;
                    REG_TURNOVER:  turn_reg  <= cfg_data;
                    REG_MUTATION:  mfrac_reg <= cfg_data[16:0];
                    REG_MIGRATION: mig_reg   <= cfg_data;
                    REG_CAPACITY:  cap_reg   <= cfg_data[19:0];
                    REG_THRESHOLD: thr_reg   <= cfg_data[19:0];
                    REG_INIT_CNT:  icnt_reg  <= cfg_data[19:0];
                    default:       birth_reg <= birth_reg;
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != S_FINISH)
                out_valid_reg <= 1'b0;

            if ((is_mul || is_div) && !run_reg)
                run_reg <= 1'b1;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op;
                        patch_reg <= patch_total;
                        dt_reg    <= time_step;
                        pb_reg    <= $signed({40'd0, birth_reg});
                        pd_reg    <= $signed({40'd0, death_reg});
                        ext_reg   <= 1'b0;
                        state_reg <= (birth_reg > death_reg) ? S_T1_MUL : S_EVENT;
                    end
                end
                S_T1_MUL:
                begin
                    dp_reg    <= diff1 * patch_reg;
                    state_reg <= S_T1_DIV;
                end
                S_T1_DIV:
                begin
                    if (div_done)
                    begin
                        pb_reg    <= pb_term;
                        run_reg   <= 1'b0;
                        state_reg <= S_T2_MUL;
                    end
                end
                S_T2_MUL:
                begin
                    dp_reg    <= diff2 * patch_reg;
                    state_reg <= S_T2_DIV;
                end
                S_T2_DIV:
                begin
                    if (div_done)
                    begin
                        pd_reg    <= pd_term;
                        run_reg   <= 1'b0;
                        state_reg <= S_EVENT;
                    end
                end
                S_EVENT:
                begin
                    state_reg <= (op_reg == OP_EULER) ? S_E1 : S_PREP;
                    case (op_reg)
                        OP_INIT:
                        begin
                            act_reg <= 1'b1;
                            if (icnt_reg < thr_reg)
                            begin
                                cnt_reg  <= 21'(icnt_reg);
                                amt_reg  <= '0;
                                disc_reg <= 1'b1;
                            end
                            else
                            begin
                                cnt_reg  <= '0;
                                amt_reg  <= AMT_W'({icnt_reg, {FRAC_BITS{1'b0}}});
                                disc_reg <= 1'b0;
                            end
                        end
                        OP_ADD:
                        begin
                            if (disc_reg)
                            begin
                                if (c_inc > 21'(thr_reg))
                                begin
                                    amt_reg  <= AMT_W'({c_inc, {FRAC_BITS{1'b0}}});
                                    cnt_reg  <= '0;
                                    disc_reg <= 1'b0;
                                end
                                else
                                    cnt_reg <= c_inc;
                            end
                            else
                                amt_reg <= a_inc[AMT_W] ? AMT_MAX : a_inc[AMT_W-1:0];
                        end
                        OP_REMOVE:
                        begin
                            if (disc_reg)
                            begin
                                cnt_reg <= c_dec;
                                if (c_dec == 21'd0)
                                begin
                                    act_reg <= 1'b0;
                                    amt_reg <= '0;
                                    ext_reg <= 1'b1;
                                end
                            end
                            else if (a_dec < AMT_W'({thr_reg, {FRAC_BITS{1'b0}}}))
                            begin
                                cnt_reg  <= 21'(a_dec >> FRAC_BITS);
                                amt_reg  <= '0;
                                disc_reg <= 1'b1;
                            end
                            else
                                amt_reg <= a_dec;
                        end
                        default:
                        begin
                            amt_reg <= amt_reg;
                        end
                    endcase
                end
                S_E1:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= r1;
                        run_reg   <= 1'b0;
                        state_reg <= S_E2;
                    end
                end
                S_E2:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= apply_sign(tmp_reg[63], mul_res);
                        run_reg   <= 1'b0;
                        state_reg <= S_E3;
                    end
                end
                S_E3:
                begin
                    if (mul_done)
                    begin
                        if (nv[63])
                            amt_reg <= '0;
                        else if (|nv[62:AMT_W])
                            amt_reg <= AMT_MAX;
                        else
                            amt_reg <= nv[AMT_W-1:0];
                        run_reg   <= 1'b0;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    omgx_reg <= omg * cnt_reg;
                    gx_reg   <= g * cnt_reg;
                    if (disc_reg)
                        state_reg <= S_P0;
                    else
                    begin
                        p0_reg    <= '0;
                        p1_reg    <= '0;
                        state_reg <= S_P2;
                    end
                end
                S_P0:
                begin
                    if (mul_done)
                    begin
                        p0_reg    <= 48'(apply_sign(pb_reg[63], mul_res));
                        run_reg   <= 1'b0;
                        state_reg <= S_P1;
                    end
                end
                S_P1:
                begin
                    if (mul_done)
                    begin
                        p1_reg    <= 48'(apply_sign(pd_reg[63], mul_res));
                        run_reg   <= 1'b0;
                        state_reg <= S_P2;
                    end
                end
                S_P2:
                begin
                    if (mul_done)
                    begin
                        p2_reg    <= 48'(apply_sign(1'b0, mul_res));
                        run_reg   <= 1'b0;
                        state_reg <= disc_reg ? S_P3 : S_GM;
                    end
                end
                S_GM:
                begin
                    if (mul_done)
                    begin
                        gm_reg    <= mul_res[AMT_W-1:0];
                        run_reg   <= 1'b0;
                        state_reg <= S_P3;
                    end
                end
                S_P3:
                begin
                    if (mul_done)
                    begin
                        p3_reg    <= 48'(apply_sign(pb_reg[63], mul_res));
                        run_reg   <= 1'b0;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_b_reg     <= p0_reg;
                        out_d_reg     <= p1_reg;
                        out_m_reg     <= p2_reg;
                        out_u_reg     <= p3_reg;
                        out_t_reg     <= total_clamped;
                        out_cnt_reg   <= disc_reg ? 40'({cnt_reg, {FRAC_BITS{1'b0}}})
                                                  : 40'(amt_reg);
                        out_disc_reg  <= disc_reg;
                        out_act_reg   <= act_reg;
                        out_ext_reg   <= ext_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign birth_prop     = out_b_reg;
    assign death_prop     = out_d_reg;
    assign migration_prop = out_m_reg;
    assign mutation_prop  = out_u_reg;
    assign total_prop     = out_t_reg;
    assign count_out      = out_cnt_reg;
    assign is_discrete    = out_disc_reg;
    assign is_active      = out_act_reg;
    assign extinct        = out_ext_reg;

endmodule
`default_nettype wire

@@ src/hpc_checker.sv @@
`default_nettype none
module hpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [47:0] birth_prop,
    input logic signed [47:0] death_prop,
    input logic signed [47:0] total_prop,
    input logic [39:0]        count_out,
    input logic               is_discrete,
    input logic               is_active,
    input logic               extinct
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(total_prop))
        else $error("stalled result changed");

    a_extinct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && extinct |-> !is_active && is_discrete && count_out == 40'd0)
        else $error("extinction with live cell");

    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_discrete |-> birth_prop == 48'sd0 && death_prop == 48'sd0)
        else $error("continuous cell reports birth or death");

endmodule

bind hybrid_population_cell hpc_checker u_chk (.*);
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hpc_pkg::*;

    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [63:0] ONE_Q = 64'd65536;
    localparam logic [63:0] AMOUNT_MAX = (64'd1 << 40) - 1;
    localparam logic [63:0] WIDE_MAX = 64'd1 << 62;
    localparam logic [63:0] PROP_MAX = (64'd1 << 47) - 1;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] patch;
        logic [19:0] dt;
    } event_t;

    typedef struct {
        logic [47:0] bp, dp, mp, up, tp;
        logic [39:0] cnt;
        logic        disc, act, ext;
    } cell_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] op = '0;
    logic [31:0] patch_total = '0;
    logic [19:0] time_step = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [47:0] birth_prop, death_prop, migration_prop, mutation_prop, total_prop;
    logic [39:0] count_out;
    logic is_discrete, is_active, extinct;

    hybrid_population_cell dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // predictor registers and cell state
    logic [63:0] r_birth = 0, r_death = 0, r_turn = 0, r_mut = 0, r_mig = 0;
    logic [63:0] r_cap = 1, r_thr = 1, r_init = 0;
    logic [63:0] c_count = 0, c_amount = 0;
    logic c_disc = 1'b1, c_act = 1'b0;

    event_t pending_events[$];
    cell_res_t expected_results[$];
    int errors = 0;
    int sender_idle = 0, receiver_idle = 0;
    logic taken = 1'b0;

    function automatic logic [63:0] umulq(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        if (p[127:80] != 0) return '1;
        return p[79:16];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint qmul(longint a, longint b, logic [63:0] lim);
        logic [63:0] r;
        r = umulq(magnitude(a), magnitude(b));
        if (r > lim) r = lim;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint logistic(logic [63:0] x, logic [63:0] y, logic [63:0] p);
        logic [63:0] k, diff, q;
        k = (r_cap == 0) ? 64'd1 : r_cap;
        diff = x >= y ? x - y : y - x;
        q = (diff * p) / (k << 12);
        return x >= y ? longint'(q) : -longint'(q);
    endfunction

    function automatic cell_res_t predict_event(event_t ev);
        cell_res_t res;
        logic [63:0] g, omg, x, gm;
        longint pb, pd, r, rm, delta, nv, total;
        longint pr[4];
        logic ext;
        g = r_mut > ONE_Q ? ONE_Q : r_mut;
        omg = ONE_Q - g;
        pb = longint'(r_birth);
        pd = longint'(r_death);
        ext = 1'b0;
        if (r_birth > r_death)
        begin
            pb -= logistic(r_birth, r_turn, ev.patch);
            pd += logistic(r_turn, r_death, ev.patch);
        end
        case (ev.op)
            OP_INIT:
            begin
                if (r_init < r_thr)
                begin
                    c_count = r_init; c_amount = 0; c_disc = 1'b1;
                end
                else
                begin
                    c_count = 0; c_amount = r_init << 16; c_disc = 1'b0;
                end
                c_act = 1'b1;
            end
            OP_ADD:
                if (c_disc)
                begin
                    c_count = (c_count + 1) & 64'h1FFFFF;
                    if (c_count > r_thr)
                    begin
                        c_amount = c_count << 16; c_count = 0; c_disc = 1'b0;
                    end
                end
                else
                    c_amount = (c_amount + ONE_Q > AMOUNT_MAX) ? AMOUNT_MAX : c_amount + ONE_Q;
            OP_REMOVE:
                if (c_disc)
                begin
                    if (c_count > 0) c_count -= 1;
                    if (c_count == 0)
                    begin
                        c_act = 1'b0; c_amount = 0; ext = 1'b1;
                    end
                end
                else
                begin
                    c_amount = c_amount > ONE_Q ? c_amount - ONE_Q : 0;
                    if (c_amount < (r_thr << 16))
                    begin
                        c_count = c_amount >> 16; c_amount = 0; c_disc = 1'b1;
                    end
                end
            OP_EULER:
            begin
                r = qmul(longint'(omg), pb, WIDE_MAX) - pd;
                rm = qmul(r, longint'(c_amount), WIDE_MAX);
                delta = qmul(rm, longint'({44'd0, ev.dt}), WIDE_MAX);
                nv = longint'(c_amount) + delta;
                if (nv < 0) nv = 0;
                if (nv > longint'(AMOUNT_MAX)) nv = longint'(AMOUNT_MAX);
                c_amount = 64'(nv);
            end
            default: ;
        endcase
        if (c_disc)
        begin
            x = c_count;
            pr[0] = qmul(longint'(omg * x), pb, PROP_MAX);
            pr[1] = qmul(longint'(x << 16), pd, PROP_MAX);
            pr[2] = qmul(longint'(r_mig), longint'(x << 16), PROP_MAX);
            pr[3] = qmul(longint'(g * x), pb, PROP_MAX);
        end
        else
        begin
            gm = umulq(g, c_amount);
            pr[0] = 0;
            pr[1] = 0;
            pr[2] = qmul(longint'(r_mig), longint'(c_amount), PROP_MAX);
            pr[3] = qmul(longint'(gm), pb, PROP_MAX);
        end
        total = pr[0] + pr[1] + pr[2] + pr[3];
        if (total > longint'(PROP_MAX)) total = longint'(PROP_MAX);
        if (total < -longint'(PROP_MAX)) total = -longint'(PROP_MAX);
        res.bp = pr[0][47:0];
        res.dp = pr[1][47:0];
        res.mp = pr[2][47:0];
        res.up = pr[3][47:0];
        res.tp = total[47:0];
        res.cnt = c_disc ? 40'(c_count << 16) : c_amount[39:0];
        res.disc = c_disc;
        res.act = c_act;
        res.ext = ext;
        return res;
    endfunction

    // driver: present the next pending event once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || taken))
        begin
            if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle)
            begin
                event_t ev;
                ev = pending_events.pop_front();
                op <= ev.op;
                patch_total <= ev.patch;
                time_step <= ev.dt;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= $urandom_range(99) < receiver_idle;
    end

    always @(posedge clk)
    begin
        taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            event_t ev;
            ev.op = op;
            ev.patch = patch_total;
            ev.dt = time_step;
            expected_results.push_back(predict_event(ev));
        end
    end

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected result transaction", 64'd0, 64'd0);
            end
            else
            begin
                cell_res_t w;
                w = expected_results.pop_front();
                if (birth_prop !== w.bp) report("birth_prop", birth_prop, w.bp);
                if (death_prop !== w.dp) report("death_prop", death_prop, w.dp);
                if (migration_prop !== w.mp) report("migration_prop", migration_prop, w.mp);
                if (mutation_prop !== w.up) report("mutation_prop", mutation_prop, w.up);
                if (total_prop !== w.tp) report("total_prop", total_prop, w.tp);
                if (count_out !== w.cnt) report("count_out", count_out, w.cnt);
                if (is_discrete !== w.disc) report("is_discrete", is_discrete, w.disc);
                if (is_active !== w.act) report("is_active", is_active, w.act);
                if (extinct !== w.ext) report("extinct", extinct, w.ext);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_BIRTH:     r_birth = val;
            REG_DEATH:     r_death = val;
            REG_TURNOVER:  r_turn = val;
            REG_MUTATION:  r_mut = val & 24'h1FFFF;
            REG_MIGRATION: r_mig = val;
            REG_CAPACITY:  r_cap = val & 24'hFFFFF;
            REG_THRESHOLD: r_thr = val & 24'hFFFFF;
            default:       r_init = val & 24'hFFFFF;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] b, logic [23:0] d, logic [23:0] t, logic [23:0] g,
                             logic [23:0] m, logic [23:0] k, logic [23:0] th, logic [23:0] n);
        write_reg(REG_BIRTH, b);
        write_reg(REG_DEATH, d);
        write_reg(REG_TURNOVER, t);
        write_reg(REG_MUTATION, g);
        write_reg(REG_MIGRATION, m);
        write_reg(REG_CAPACITY, k);
        write_reg(REG_THRESHOLD, th);
        write_reg(REG_INIT_CNT, n);
    endtask

    task automatic push_event(logic [2:0] o, logic [31:0] p, logic [19:0] dt);
        event_t ev;
        ev.op = o;
        ev.patch = p;
        ev.dt = dt;
        pending_events.push_back(ev);
    endtask

    // hold until the block has drained
    task automatic drain();
        wait (pending_events.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [2:0] random_op();
        int w;
        w = $urandom_range(99);
        if (w < 8) return OP_INIT;
        if (w < 38) return OP_ADD;
        if (w < 66) return OP_REMOVE;
        if (w < 90) return OP_EULER;
        if (w < 96) return OP_QUERY;
        return 3'($urandom_range(7, 5));
    endfunction

    task automatic random_phase(int n);
        push_event(OP_INIT, $urandom, 20'($urandom));
        for (int i = 0; i < n; i++)
            push_event(random_op(), $urandom_range(3) == 0 ? $urandom : $urandom_range(65535),
                       20'($urandom));
    endtask

    function automatic logic [23:0] rand_rate();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(200000));
            2: return 24'($urandom_range(70000));
            default: return 24'hFFFFFF;
        endcase
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default settings: query, extinction at count zero, unknown ops
        push_event(OP_QUERY, 32'h0, 20'h0);
        push_event(OP_ADD, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_INIT, 32'h0, 20'h0);
        push_event(OP_REMOVE, 32'h0, 20'h0);
        push_event(OP_REMOVE, 32'hFFFFFFFF, 20'h0);
        push_event(OP_EULER, 32'h12345, 20'hFFFFF);
        push_event(3'd5, 32'h0, 20'h0);
        push_event(3'd6, 32'h0, 20'h0);
        push_event(3'd7, 32'h0, 20'h0);
        drain();

        // extremes: saturation, mutation above one, capacity and threshold zero
        write_all(24'hFFFFFF, 24'h0, 24'h7FFFFF, 24'h1FFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0);
        push_event(OP_INIT, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_ADD, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_EULER, 32'h0, 20'hFFFFF);
        push_event(OP_REMOVE, 32'h0, 20'h0);
        push_event(OP_QUERY, 32'hFFFFFFFF, 20'h0);
        drain();
        write_all(24'hFFFFFF, 24'h0, 24'h0, 24'h10000, 24'hFFFFFF, 24'hFFFFF, 24'hFFFFF,
                  24'hFFFFF);
        push_event(OP_INIT, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_EULER, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_EULER, 32'h0, 20'hFFFFF);
        push_event(OP_ADD, 32'h0, 20'h0);
        push_event(OP_REMOVE, 32'h0, 20'h0);
        drain();
        write_reg(REG_INIT_CNT, 24'h1);
        write_all(24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'h8000, 24'h0, 24'h1, 24'h2, 24'h3);
        push_event(OP_INIT, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_EULER, 32'hFFFFFFFF, 20'hFFFFF);
        push_event(OP_REMOVE, 32'h1000, 20'h0);
        push_event(OP_ADD, 32'h1000, 20'h0);
        push_event(OP_ADD, 32'h1000, 20'h0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            sender_idle = ph < 2 ? 24 : (ph < 4 ? 81 : 0);
            receiver_idle = ph < 2 ? 81 : (ph < 4 ? 24 : 0);
            write_all(rand_rate(), rand_rate(), rand_rate(), 24'($urandom_range(70000)),
                      rand_rate(),
                      $urandom_range(3) == 0 ? 24'($urandom_range(1048575))
                                             : 24'($urandom_range(1, 40)),
                      $urandom_range(4) == 0 ? 24'($urandom_range(1048575))
                                             : 24'($urandom_range(0, 12)),
                      24'($urandom_range(0, 16)));
            for (int s = 0; s < 4; s++)
            begin
                random_phase(56);
                drain();
                write_reg(REG_INIT_CNT, $urandom_range(2) == 0 ? 24'($urandom_range(1048575))
                                                               : 24'($urandom_range(0, 16)));
                write_reg(REG_BIRTH, rand_rate());
            end
        end

        repeat (600) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
